// ----- hw/rtl/etsvm_pkg.sv -----
package etsvm_pkg;

    localparam int MAX_VOICES_DEF = 12;
    localparam int CLIP_DEPTH_DEF = 65536;
    localparam int NUM_CLIPS      = 5;
    localparam int LEN_W          = 17;
    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 20;
    localparam int ACTIVE_W       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CLIP_ID_W      = 3;
    localparam int SUM_MAX        = 524287;
    localparam int SUM_MIN        = -524288;
    localparam int ACTIVE_MAX     = 15;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_MIX   = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic [2:0] EV_MOTOR_ON    = 3'd0;
    localparam logic [2:0] EV_MOTOR_READY = 3'd1;
    localparam logic [2:0] EV_MOTOR_OFF   = 3'd2;
    localparam logic [2:0] EV_STEP        = 3'd3;
    localparam logic [2:0] EV_INDEX       = 3'd4;

    localparam logic [CLIP_ID_W-1:0] CLIP_SPINUP   = 3'd0;
    localparam logic [CLIP_ID_W-1:0] CLIP_HUM      = 3'd1;
    localparam logic [CLIP_ID_W-1:0] CLIP_SPINDOWN = 3'd2;
    localparam logic [CLIP_ID_W-1:0] CLIP_STEP     = 3'd3;
    localparam logic [CLIP_ID_W-1:0] CLIP_TICK     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPINDOWN_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN     = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DROP = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

// ----- hw/rtl/etsvm_ram.sv -----
module etsvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/event_triggered_sample_voice_mixer.sv -----
// Load and start events are taken in the idle state, which the block does not leave.
// Motor-off: one voice-table read per voice; looping voices are dropped, then spin-down starts.
// Sample tick: one voice per cycle on the voice table's read port, then the clip read and
// the accumulate; the saturated sum is registered once the output register is free.
// Reset empties the voice table, clears the enable and sets clip lengths to one;
// clip memory is not cleared and holds whatever is loaded.
module event_triggered_sample_voice_mixer
    import etsvm_pkg::*;
#(
    parameter int MAX_VOICES = MAX_VOICES_DEF,
    parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEN_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [2:0]            event_kind,
    input  logic [2:0]            clip_select,
    input  logic [15:0]           clip_address,
    input  logic signed [15:0]    pcm_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [SUM_W-1:0] mix_sum,
    output logic [ACTIVE_W-1:0]   active_voices
);

    localparam int PW    = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
    localparam int NW    = PW + 1;
    localparam int VE_W  = CLIP_ID_W + PW + 1;
    localparam int VI_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int CA_W  = $clog2(NUM_CLIPS * CLIP_DEPTH);
    localparam int ACC_W = ($clog2(MAX_VOICES) + 17 > 21) ? $clog2(MAX_VOICES) + 17 : 21;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SUM_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SUM_MIN);

    state_t state_reg, state_next;

    logic                    en_reg;
    logic [LEN_W-1:0]        len_reg [NUM_CLIPS];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]        wr_idx_reg, wr_idx_next;
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0] mix_sum_reg;
    logic [ACTIVE_W-1:0]     active_reg;
    logic                    out_load;

    logic             vr_we, vr_re;
    logic [VI_W-1:0]  vr_waddr, vr_raddr;
    logic [VE_W-1:0]  vr_wdata, vr_rdata;
    logic             cr_we, cr_re;
    logic [CA_W-1:0]  cr_waddr, cr_raddr;
    logic [SAMPLE_W-1:0] cr_rdata;

    logic                 accept;
    logic [CLIP_ID_W-1:0] v_clip;
    logic [PW-1:0]        v_pos;
    logic                 v_loop;
    logic [NW-1:0]        pos1;
    logic [LEN_W-1:0]     cur_len;
    logic [NW-1:0]        eff_len;
    logic                 ended;
    logic                 keep;
    logic [PW-1:0]        new_pos;
    logic                 issue;
    logic                 pipe_done;
    logic                 start_req;
    logic [CLIP_ID_W-1:0] start_clip;
    logic                 start_loop;
    logic signed [SUM_W-1:0] sum_sat;

    etsvm_ram #(
        .WIDTH (VE_W),
        .DEPTH (MAX_VOICES),
        .AW    (VI_W)
    ) u_voice_ram (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .re    (vr_re),
        .raddr (vr_raddr),
        .rdata (vr_rdata)
    );

    etsvm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_CLIPS * CLIP_DEPTH),
        .AW    (CA_W)
    ) u_clip_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (cr_waddr),
        .wdata (pcm_word),
        .re    (cr_re),
        .raddr (cr_raddr),
        .rdata (cr_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    // clip load port
    assign cr_we    = accept && (op == OP_LOAD) && (clip_select < CLIP_ID_W'(NUM_CLIPS))
                      && (32'(clip_address) < 32'(CLIP_DEPTH));
    assign cr_waddr = CA_W'(CA_W'(clip_select) * CA_W'(CLIP_DEPTH)) + CA_W'(clip_address);

    // voice entry decode and advance
    assign v_clip  = vr_rdata[VE_W-1 -: CLIP_ID_W];
    assign v_pos   = vr_rdata[PW:1];
    assign v_loop  = vr_rdata[0];
    assign pos1    = {1'b0, v_pos} + NW'(1);
    assign cur_len = (v_clip < CLIP_ID_W'(NUM_CLIPS)) ? len_reg[v_clip] : LEN_W'(1);

    always_comb
    begin
        if (cur_len == '0)
        begin
            eff_len = NW'(1);
        end
        else if (32'(cur_len) > 32'(CLIP_DEPTH))
        begin
            eff_len = NW'(CLIP_DEPTH);
        end
        else
        begin
            eff_len = NW'(cur_len);
        end
    end

    assign ended   = (pos1 >= eff_len);
    assign new_pos = ended ? '0 : pos1[PW-1:0];
    assign keep    = (state_reg == ST_DROP) ? !v_loop : (v_loop || !ended);

    assign cr_re    = s1_valid_reg && (state_reg == ST_MIX);
    assign cr_raddr = CA_W'(CA_W'(v_clip) * CA_W'(CLIP_DEPTH)) + CA_W'(v_pos);

    assign issue     = (rd_idx_reg < count_reg);
    assign pipe_done = !issue && !s1_valid_reg && !s2_valid_reg;
    assign vr_re     = issue && ((state_reg == ST_DROP) || (state_reg == ST_MIX));
    assign vr_raddr  = rd_idx_reg[VI_W-1:0];

    always_comb
    begin
        start_req  = 1'b0;
        start_clip = CLIP_SPINUP;
        start_loop = 1'b0;
        if (accept && (op == OP_EVENT) && en_reg)
        begin
            case (event_kind)
                EV_MOTOR_ON:
                begin
                    start_req  = 1'b1;
                    start_clip = CLIP_SPINUP;
                end
                EV_MOTOR_READY:
                begin
                    start_req  = 1'b1;
                    start_clip = CLIP_HUM;
                    start_loop = 1'b1;
                end
                EV_STEP:
                begin
                    start_req  = 1'b1;
                    start_clip = CLIP_STEP;
                end
                EV_INDEX:
                begin
                    start_req  = 1'b1;
                    start_clip = CLIP_TICK;
                end
                default:
                begin
                    start_req = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        s1_valid_next = 1'b0;
        s2_valid_next = 1'b0;
        acc_next      = acc_reg;
        out_load      = 1'b0;
        vr_we         = 1'b0;
        vr_waddr      = count_reg[VI_W-1:0];
        vr_wdata      = {start_clip, {PW{1'b0}}, start_loop};

        case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                if (start_req && (count_reg < CNT_W'(MAX_VOICES)))
                begin
                    vr_we      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                if (accept && (op == OP_EVENT) && en_reg && (event_kind == EV_MOTOR_OFF))
                begin
                    state_next = ST_DROP;
                end
                if (accept && (op == OP_MIX))
                begin
                    acc_next   = '0;
                    state_next = ST_MIX;
                end
            end
            ST_DROP, ST_MIX:
            begin
                if (issue)
                begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    s1_valid_next = 1'b1;
                end
                if (s1_valid_reg)
                begin
                    s2_valid_next = (state_reg == ST_MIX);
                    if (keep)
                    begin
                        vr_we       = 1'b1;
                        vr_waddr    = wr_idx_reg[VI_W-1:0];
                        vr_wdata    = (state_reg == ST_MIX) ? {v_clip, new_pos, v_loop}
                                                            : vr_rdata;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                end
                if (s2_valid_reg)
                begin
                    acc_next = acc_reg + {{(ACC_W-SAMPLE_W){cr_rdata[SAMPLE_W-1]}}, cr_rdata};
                end
                if (pipe_done)
                begin
                    count_next = wr_idx_reg;
                    if (state_reg == ST_MIX)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // spin-down starts after the loops are gone
                        state_next = ST_IDLE;
                        vr_waddr   = wr_idx_reg[VI_W-1:0];
                        vr_wdata   = {CLIP_SPINDOWN, {PW{1'b0}}, 1'b0};
                        if (wr_idx_reg < CNT_W'(MAX_VOICES))
                        begin
                            vr_we      = 1'b1;
                            count_next = wr_idx_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sum_sat = SUM_W'(SAT_HI);
        end
        else if (acc_reg < SAT_LO)
        begin
            sum_sat = SUM_W'(SAT_LO);
        end
        else
        begin
            sum_sat = acc_reg[SUM_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            for (int i = 0; i < NUM_CLIPS; i++)
            begin
                len_reg[i] <= LEN_W'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:       en_reg     <= cfg_data[0];
                CFG_SPINUP_LEN:   len_reg[0] <= cfg_data;
                CFG_HUM_LEN:      len_reg[1] <= cfg_data;
                CFG_SPINDOWN_LEN: len_reg[2] <= cfg_data;
                CFG_STEP_LEN:     len_reg[3] <= cfg_data;
                CFG_TICK_LEN:     len_reg[4] <= cfg_data;
                default:
                begin
                    en_reg <= en_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (out_load)
        begin
            mix_sum_reg <= sum_sat;
            active_reg  <= (32'(count_reg) > ACTIVE_MAX) ? ACTIVE_W'(ACTIVE_MAX)
                                                          : ACTIVE_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign mix_sum       = mix_sum_reg;
    assign active_voices = active_reg;

endmodule

// ----- tb/sv/tb_event_triggered_sample_voice_mixer.sv -----
module tb_event_triggered_sample_voice_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import etsvm_pkg::*;

    localparam int VOICES = MAX_VOICES_DEF;
    localparam int DEPTH = CLIP_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  kind;
        logic [2:0]  sel;
        logic [15:0] addr;
        logic [15:0] word;
    } cmd_t;

    typedef struct packed {
        logic [CLIP_ID_W-1:0] clip;
        logic [16:0]          pos;
        logic                 looping;
    } voice_t;

    typedef struct packed {
        logic                            enabled;
        logic [NUM_CLIPS-1:0][LEN_W-1:0] len;
        logic [4:0]                      count;
        voice_t [VOICES-1:0]             slot;
    } mixer_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic [ACTIVE_W-1:0]     voices;
    } mix_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [LEN_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               op = '0;
    logic [2:0]               event_kind = '0;
    logic [2:0]               clip_select = '0;
    logic [15:0]              clip_address = '0;
    logic signed [15:0]       pcm_word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SUM_W-1:0]  mix_sum;
    logic [ACTIVE_W-1:0]      active_voices;

    cmd_t                     pending_cmds[$];
    mix_out_t                 expected_mixes[$];
    mixer_t                   mixer_now;
    mixer_t                   mixer_plan;
    logic signed [15:0]       pcm_mem [0:NUM_CLIPS*DEPTH-1];
    bit                       loaded [0:NUM_CLIPS*DEPTH-1];
    logic                     in_acc = 1'b0;
    cmd_t                     next_cmd;
    mix_out_t                 want;
    int                       send_gap = 0;
    int                       send_calm = 0;
    int                       recv_gap = 0;
    int                       recv_calm = 0;
    int                       mismatches = 0;
    int                       cycles = 0;
    int                       queued = 0;

    event_triggered_sample_voice_mixer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .event_kind   (event_kind),
        .clip_select  (clip_select),
        .clip_address (clip_address),
        .pcm_word     (pcm_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mix_sum      (mix_sum),
        .active_voices(active_voices)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic mixer_t blank_mixer();
        mixer_t m;
        m = '0;
        for (int c = 0; c < NUM_CLIPS; c++)
        begin
            m.len[c] = LEN_W'(1);
        end
        return m;
    endfunction

    function automatic mixer_t apply_reg(mixer_t m, logic [CFG_IDX_W-1:0] idx,
                                         logic [LEN_W-1:0] val);
        if (idx == CFG_ENABLE)
            m.enabled = val[0];
        else if (idx >= CFG_SPINUP_LEN && idx <= CFG_TICK_LEN)
            m.len[idx - CFG_SPINUP_LEN] = val;
        return m;
    endfunction

    function automatic int eff_len(mixer_t m, logic [CLIP_ID_W-1:0] clip);
        int n;
        n = int'(m.len[clip]);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    function automatic mixer_t start_voice(mixer_t m, logic [CLIP_ID_W-1:0] clip,
                                           logic looping);
        if (m.count < VOICES)
        begin
            m.slot[m.count].clip = clip;
            m.slot[m.count].pos = '0;
            m.slot[m.count].looping = looping;
            m.count = m.count + 5'd1;
        end
        return m;
    endfunction

    function automatic mixer_t drop_loops(mixer_t m);
        mixer_t r;
        r = m;
        r.count = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (i < m.count && !m.slot[i].looping)
            begin
                r.slot[r.count] = m.slot[i];
                r.count = r.count + 5'd1;
            end
        end
        return r;
    endfunction

    function automatic mixer_t on_event(mixer_t m, logic [2:0] kind);
        if (!m.enabled)
            return m;
        case (kind)
            EV_MOTOR_ON:    return start_voice(m, CLIP_SPINUP, 1'b0);
            EV_MOTOR_READY: return start_voice(m, CLIP_HUM, 1'b1);
            EV_MOTOR_OFF:   return start_voice(drop_loops(m), CLIP_SPINDOWN, 1'b0);
            EV_STEP:        return start_voice(m, CLIP_STEP, 1'b0);
            EV_INDEX:       return start_voice(m, CLIP_TICK, 1'b0);
            default:        return m;
        endcase
    endfunction

    function automatic int sample_index(voice_t v);
        return int'(v.clip) * DEPTH + (int'(v.pos) % DEPTH);
    endfunction

    function automatic int mix_total(mixer_t m);
        int acc;
        acc = 0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (i < m.count)
                acc = acc + int'(pcm_mem[sample_index(m.slot[i])]);
        end
        return acc;
    endfunction

    function automatic mixer_t advance(mixer_t m);
        mixer_t r;
        int     p;
        r = m;
        r.count = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (i < m.count)
            begin
                p = int'(m.slot[i].pos) + 1;
                if (p < eff_len(m, m.slot[i].clip) || m.slot[i].looping)
                begin
                    r.slot[r.count] = m.slot[i];
                    r.slot[r.count].pos = (p < eff_len(m, m.slot[i].clip)) ? 17'(p) : '0;
                    r.count = r.count + 5'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic cmd_t mk_cmd(logic [1:0] o, logic [2:0] k, logic [2:0] s,
                                    logic [15:0] a, logic [15:0] w);
        cmd_t c;
        c.op = o;
        c.kind = k;
        c.sel = s;
        c.addr = a;
        c.word = w;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        c = mk_cmd(2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom),
                   16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 40)
            c.op = OP_MIX;
        else if (r < 72)
        begin
            c.op = OP_EVENT;
            if ($urandom_range(0, 9) != 0)
                c.kind = 3'($urandom_range(0, 4));
        end
        else if (r < 96)
        begin
            c.op = OP_LOAD;
            if ($urandom_range(0, 9) != 0)
                c.sel = 3'($urandom_range(0, NUM_CLIPS - 1));
            if ($urandom_range(0, 1) == 0)
                c.addr = 16'($urandom_range(0, 31));
        end
        else
            c.op = OP_NONE;
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] phase_len(int ph);
        int r;
        if (ph == 1)
            return '1;
        if (ph == 2)
            return LEN_W'(DEPTH);
        if (ph == 4)
            return '0;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return LEN_W'(DEPTH);
        return LEN_W'($urandom_range(1, 24));
    endfunction

    function automatic int idle_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // every sample a tick will read must have been loaded first
    task automatic queue_cmd(input cmd_t c);
        int   idx;
        cmd_t fill;
        if (c.op == OP_MIX)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (i < mixer_plan.count)
                begin
                    idx = sample_index(mixer_plan.slot[i]);
                    if (!loaded[idx])
                    begin
                        fill = mk_cmd(OP_LOAD, 3'($urandom), mixer_plan.slot[i].clip,
                                      16'(mixer_plan.slot[i].pos), 16'($urandom));
                        pending_cmds.insert(pending_cmds.size(), fill);
                        queued++;
                        loaded[idx] = 1'b1;
                    end
                end
            end
            mixer_plan = advance(mixer_plan);
        end
        else if (c.op == OP_EVENT)
            mixer_plan = on_event(mixer_plan, c.kind);
        else if (c.op == OP_LOAD && c.sel < NUM_CLIPS)
            loaded[int'(c.sel) * DEPTH + int'(c.addr)] = 1'b1;
        pending_cmds.insert(pending_cmds.size(), c);
        queued++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        mixer_plan = apply_reg(mixer_plan, idx, val);
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_mixes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_acc))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                op <= next_cmd.op;
                event_kind <= next_cmd.kind;
                clip_select <= next_cmd.sel;
                clip_address <= next_cmd.addr;
                pcm_word <= next_cmd.word;
                in_valid <= 1'b1;
                send_gap = idle_gap(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_gap = idle_gap(recv_calm);
        end
    end

    always @(posedge clk)
    begin
        in_acc <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_mixes.size() == 0)
                begin
                    $error("unexpected mix item: mix_sum %0d active_voices %0d",
                           mix_sum, active_voices);
                    mismatches++;
                end
                else
                begin
                    want = expected_mixes.pop_front();
                    if (mix_sum !== want.total)
                    begin
                        $error("mix_sum expected %0d got %0d", want.total, mix_sum);
                        mismatches++;
                    end
                    if (active_voices !== want.voices)
                    begin
                        $error("active_voices expected %0d got %0d", want.voices,
                               active_voices);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                mixer_now = apply_reg(mixer_now, cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                case (op)
                    OP_EVENT: mixer_now = on_event(mixer_now, event_kind);
                    OP_LOAD:
                    begin
                        if (clip_select < NUM_CLIPS)
                            pcm_mem[int'(clip_select) * DEPTH + int'(clip_address)] = pcm_word;
                    end
                    OP_MIX:
                    begin
                        want.total = SUM_W'(mix_total(mixer_now));
                        mixer_now = advance(mixer_now);
                        want.voices = ACTIVE_W'(mixer_now.count);
                        expected_mixes.insert(expected_mixes.size(), want);
                    end
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL event_triggered_sample_voice_mixer");
            $finish;
        end
    end

    initial
    begin
        int k;
        int c;
        int ph;
        int base;
        mixer_now = blank_mixer();
        mixer_plan = blank_mixer();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // disabled after reset: events do nothing, empty mix
        queue_cmd(mk_cmd(OP_EVENT, EV_MOTOR_ON, '0, '0, '0));
        queue_cmd(mk_cmd(OP_EVENT, EV_MOTOR_READY, 3'h7, 16'hFFFF, 16'hFFFF));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));
        queue_cmd(mk_cmd(OP_NONE, 3'h7, 3'h7, 16'hFFFF, 16'hFFFF));
        settle();

        set_reg(CFG_ENABLE, LEN_W'(1));
        set_reg(CFG_SPINUP_LEN, LEN_W'(2));
        set_reg(CFG_HUM_LEN, LEN_W'(3));
        set_reg(CFG_SPINDOWN_LEN, LEN_W'(2));
        set_reg(CFG_STEP_LEN, LEN_W'(1));
        set_reg(CFG_TICK_LEN, '0);

        for (k = 0; k < 3; k++)
            queue_cmd(mk_cmd(OP_LOAD, '0, CLIP_HUM, 16'(k), 16'h7FFF));
        queue_cmd(mk_cmd(OP_LOAD, '0, CLIP_SPINUP, '0, 16'h8000));
        queue_cmd(mk_cmd(OP_LOAD, '0, CLIP_TICK, 16'hFFFF, 16'h8000));
        queue_cmd(mk_cmd(OP_LOAD, '0, 3'h7, '0, 16'h1234));
        for (k = 0; k < 8; k++)
            queue_cmd(mk_cmd(OP_EVENT, 3'(k), '0, '0, '0));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));
        // fill all twelve voice slots with hum
        repeat (12) queue_cmd(mk_cmd(OP_EVENT, EV_MOTOR_READY, '0, '0, '0));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));
        queue_cmd(mk_cmd(OP_EVENT, EV_MOTOR_OFF, '0, '0, '0));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));
        queue_cmd(mk_cmd(OP_MIX, '0, '0, '0, '0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            set_reg(CFG_ENABLE, (ph == 5) ? LEN_W'(0) : LEN_W'(1));
            for (c = 0; c < NUM_CLIPS; c++)
                set_reg(CFG_IDX_W'(CFG_SPINUP_LEN + c), phase_len(ph));
            // loads added ahead of ticks count toward the phase's items
            base = queued;
            while (queued - base < ITEMS_PER_PHASE)
                queue_cmd(rand_cmd());
        end
        settle();

        if (mismatches == 0 && expected_mixes.size() == 0)
            $display("PASS event_triggered_sample_voice_mixer");
        else
            $display("FAIL event_triggered_sample_voice_mixer");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/etsvm_pkg.sv
hw/rtl/etsvm_ram.sv
hw/rtl/event_triggered_sample_voice_mixer.sv
tb/sv/tb_event_triggered_sample_voice_mixer.sv
